[hdl/rational_fraction_alu_defines.svh]
// assertion macros for the rational fraction alu
// used by files that assert; expects clk and rst_n in scope
`ifndef RATIONAL_FRACTION_ALU_DEFINES_SVH
`define RATIONAL_FRACTION_ALU_DEFINES_SVH

// same-cycle implication under reset
`define RFA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define RFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rfa_pkg.sv]
// package of the rational fraction alu: opcodes, command and status types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rfa_pkg;
  localparam int WIDTH_DEF = 32;
  localparam int DW        = 64;

  localparam logic [2:0] OP_NORM = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_NEG  = 3'd4;
  localparam logic [2:0] OP_EQ   = 3'd5;

  typedef enum logic [4:0] {
    C_NONE, C_LOAD, C_RED_A, C_RED_B, C_GCD_START, C_GCD_STEP,
    C_DIV_N, C_DIV_D, C_DIV_STEP, C_TAKE_N, C_TAKE_D, C_STORE_A, C_STORE_B,
    C_M_T1, C_M_T2, C_M_NN, C_M_DD, C_M_BNAD, C_ADD_FIX, C_MUL_FIX,
    C_RES_A, C_RES_NEG, C_RES_EQ, C_RES_ERR, C_RES_ZERO, C_RES_R
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t code;
  } rfa_cmd_t;

  typedef struct packed {
    logic       gcd_done;
    logic       div_last;
    logic       a_zero;
    logic       b_zero;
    logic       bn_zero;
    logic [2:0] op;
  } rfa_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RED_INIT, S_GCD0, S_GCD, S_DIVN0, S_DIVN, S_TAKEN,
    S_DIVD0, S_DIVD, S_TAKED, S_STORE, S_RES, S_M1, S_M2, S_M3, S_FIX, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_A, PH_B, PH_R} phase_t;
endpackage
`default_nettype wire

[hdl/rfa_if.sv]
// channel interfaces of the rational fraction alu: operand and result items
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface rfa_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;
  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] res_num;
  logic        [62:0] res_den;
  logic               is_equal;
  logic               status;
  modport source (output valid, res_num, res_den, is_equal, status, input ready);
  modport sink   (input valid, res_num, res_den, is_equal, status, output ready);
endinterface
`default_nettype wire

[hdl/rfa_datapath.sv]
// datapath of the rational fraction alu: operands, binary gcd, divider, multiplier
// depends on rfa_pkg
`timescale 1ns / 1ps
`default_nettype none
module rfa_datapath #(
  parameter int WIDTH = rfa_pkg::WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rfa_pkg::rfa_cmd_t  cmd,
  input  wire logic        [2:0]  opcode,
  input  wire logic signed [31:0] a_num,
  input  wire logic signed [31:0] a_den,
  input  wire logic signed [31:0] b_num,
  input  wire logic signed [31:0] b_den,
  output rfa_pkg::rfa_stat_t      stat,
  output logic signed [63:0]      res_num,
  output logic        [62:0]      res_den,
  output logic                    is_equal,
  output logic                    status
);
  import rfa_pkg::*;

  logic [WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic             sa_r, sb_r;
  logic [2:0]       op_r;
  logic [DW-1:0]    rn_r, rd_r, t1_r, t2_r;
  logic             rs_r;
  logic [DW-1:0]    gx_r, gy_r, g_r;
  logic [5:0]       gk_r;
  logic [DW:0]      rem_r;
  logic [DW-1:0]    q_r;
  logic [5:0]       cnt_r;
  logic signed [63:0] res_num_r;
  logic [62:0]      res_den_r;
  logic             eq_r, st_r;

  function automatic logic [WIDTH-1:0] mag(input logic [31:0] v);
    logic [WIDTH-1:0] w;
    w = v[WIDTH-1:0];
    return w[WIDTH-1] ? (~w + 1'b1) : w;
  endfunction

  // multiplier operand select, one product per cycle
  logic [WIDTH-1:0]   mx, my;
  logic [2*WIDTH-1:0] prod;
  always_comb begin
    mx = an_r;
    my = bd_r;
    case (cmd.code)
      C_M_T2, C_M_BNAD: begin mx = bn_r; my = ad_r; end
      C_M_NN:           begin mx = an_r; my = bn_r; end
      C_M_DD:           begin mx = ad_r; my = bd_r; end
      default:          begin mx = an_r; my = bd_r; end
    endcase
  end
  assign prod = mx * my;

  logic [DW:0] rem_sh;
  assign rem_sh = {rem_r[DW-1:0], q_r[DW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (cmd.code)
        C_LOAD: begin
          op_r <= opcode;
          an_r <= mag(a_num);
          ad_r <= mag(a_den);
          bn_r <= mag(b_num);
          bd_r <= mag(b_den);
          sa_r <= a_num[WIDTH-1] ^ a_den[WIDTH-1];
          sb_r <= b_num[WIDTH-1] ^ b_den[WIDTH-1];
        end
        C_RED_A: begin rn_r <= DW'(an_r); rd_r <= DW'(ad_r); rs_r <= sa_r; end
        C_RED_B: begin rn_r <= DW'(bn_r); rd_r <= DW'(bd_r); rs_r <= sb_r; end
        C_GCD_START: begin gx_r <= rn_r; gy_r <= rd_r; gk_r <= '0; end
        C_GCD_STEP: begin
          if (gx_r == '0) begin
            g_r <= gy_r << gk_r;
          end else if (gy_r == '0) begin
            g_r <= gx_r << gk_r;
          end else if (!gx_r[0] && !gy_r[0]) begin
            gx_r <= gx_r >> 1;
            gy_r <= gy_r >> 1;
            gk_r <= gk_r + 6'd1;
          end else if (!gx_r[0]) begin
            gx_r <= gx_r >> 1;
          end else if (!gy_r[0]) begin
            gy_r <= gy_r >> 1;
          end else if (gx_r >= gy_r) begin
            gx_r <= gx_r - gy_r;
          end else begin
            gy_r <= gy_r - gx_r;
          end
        end
        C_DIV_N: begin rem_r <= '0; q_r <= rn_r; cnt_r <= '0; end
        C_DIV_D: begin rem_r <= '0; q_r <= rd_r; cnt_r <= '0; end
        C_DIV_STEP: begin
          cnt_r <= cnt_r + 6'd1;
          if (rem_sh >= {1'b0, g_r}) begin
            rem_r <= rem_sh - {1'b0, g_r};
            q_r   <= {q_r[DW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r   <= {q_r[DW-2:0], 1'b0};
          end
        end
        C_TAKE_N: rn_r <= q_r;
        C_TAKE_D: begin
          rd_r <= q_r;
          if (rn_r == '0) rs_r <= 1'b0;
        end
        C_STORE_A: begin an_r <= rn_r[WIDTH-1:0]; ad_r <= rd_r[WIDTH-1:0]; sa_r <= rs_r; end
        C_STORE_B: begin bn_r <= rn_r[WIDTH-1:0]; bd_r <= rd_r[WIDTH-1:0]; sb_r <= rs_r; end
        C_M_T1, C_M_NN: t1_r <= DW'(prod);
        C_M_T2:         t2_r <= DW'(prod);
        C_M_DD, C_M_BNAD: rd_r <= DW'(prod);
        C_ADD_FIX: begin
          if (sa_r == sb_r) begin
            rn_r <= t1_r + t2_r;
            rs_r <= sa_r;
          end else if (t1_r >= t2_r) begin
            rn_r <= t1_r - t2_r;
            rs_r <= sa_r;
          end else begin
            rn_r <= t2_r - t1_r;
            rs_r <= sb_r;
          end
        end
        C_MUL_FIX: begin rn_r <= t1_r; rs_r <= sa_r ^ sb_r; end
        C_RES_A, C_RES_NEG: begin
          // negate flips the numerator sign only, zero stays 0/1
          res_num_r <= ((cmd.code == C_RES_NEG) && (an_r != '0)) != sa_r ?
                       -$signed(64'(an_r)) : $signed(64'(an_r));
          res_den_r <= 63'(ad_r);
          eq_r <= 1'b0;
          st_r <= 1'b0;
        end
        C_RES_EQ: begin
          res_num_r <= '0;
          res_den_r <= '0;
          eq_r <= (sa_r == sb_r) && (an_r == bn_r) && (ad_r == bd_r);
          st_r <= 1'b0;
        end
        C_RES_ERR, C_RES_ZERO: begin
          res_num_r <= '0;
          res_den_r <= '0;
          eq_r <= 1'b0;
          st_r <= (cmd.code == C_RES_ERR);
        end
        C_RES_R: begin
          res_num_r <= rs_r ? -$signed(rn_r) : $signed(rn_r);
          res_den_r <= rd_r[62:0];
          eq_r <= 1'b0;
          st_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign stat.gcd_done = (gx_r == '0) || (gy_r == '0);
  assign stat.div_last = (cnt_r == 6'd63);
  assign stat.a_zero   = (ad_r == '0);
  assign stat.b_zero   = (bd_r == '0);
  assign stat.bn_zero  = (bn_r == '0);
  assign stat.op       = op_r;

  assign res_num  = res_num_r;
  assign res_den  = res_den_r;
  assign is_equal = eq_r;
  assign status   = st_r;
endmodule
`default_nettype wire

[hdl/rfa_ctrl.sv]
// controller of the rational fraction alu: sequences loads, reductions and opcodes
// depends on rfa_pkg
`timescale 1ns / 1ps
`default_nettype none
module rfa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire rfa_pkg::rfa_stat_t stat,
  output rfa_pkg::rfa_cmd_t       cmd
);
  import rfa_pkg::*;

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;
  logic   uses_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= PH_A;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_comb begin
    case (stat.op) inside
      OP_ADD, OP_MUL, OP_DIV, OP_EQ: uses_b = 1'b1;
      default:                      uses_b = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cmd.code  = C_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.code  = C_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ph_nxt = PH_A;
        if (stat.op > OP_EQ) begin
          cmd.code  = C_RES_ZERO;
          state_nxt = S_OUT;
        end else if (stat.a_zero || (uses_b && stat.b_zero)) begin
          cmd.code  = C_RES_ERR;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RED_INIT;
        end
      end
      S_RED_INIT: begin
        if (ph_r == PH_A) cmd.code = C_RED_A;
        else if (ph_r == PH_B) cmd.code = C_RED_B;
        state_nxt = S_GCD0;
      end
      S_GCD0: begin cmd.code = C_GCD_START; state_nxt = S_GCD; end
      S_GCD: begin
        cmd.code = C_GCD_STEP;
        if (stat.gcd_done) state_nxt = S_DIVN0;
      end
      S_DIVN0: begin cmd.code = C_DIV_N; state_nxt = S_DIVN; end
      S_DIVN: begin
        cmd.code = C_DIV_STEP;
        if (stat.div_last) state_nxt = S_TAKEN;
      end
      S_TAKEN: begin cmd.code = C_TAKE_N; state_nxt = S_DIVD0; end
      S_DIVD0: begin cmd.code = C_DIV_D; state_nxt = S_DIVD; end
      S_DIVD: begin
        cmd.code = C_DIV_STEP;
        if (stat.div_last) state_nxt = S_TAKED;
      end
      S_TAKED: begin cmd.code = C_TAKE_D; state_nxt = S_STORE; end
      S_STORE: begin
        if (ph_r == PH_A) begin
          cmd.code = C_STORE_A;
          if (uses_b) begin
            ph_nxt    = PH_B;
            state_nxt = S_RED_INIT;
          end else begin
            state_nxt = S_RES;
          end
        end else if (ph_r == PH_B) begin
          cmd.code  = C_STORE_B;
          state_nxt = S_RES;
        end else begin
          cmd.code  = C_RES_R;
          state_nxt = S_OUT;
        end
      end
      S_RES: begin
        case (stat.op)
          OP_NORM: begin cmd.code = C_RES_A; state_nxt = S_OUT; end
          OP_NEG:  begin cmd.code = C_RES_NEG; state_nxt = S_OUT; end
          OP_EQ:   begin cmd.code = C_RES_EQ; state_nxt = S_OUT; end
          OP_DIV: begin
            if (stat.bn_zero) begin
              cmd.code  = C_RES_ERR;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_M1;
            end
          end
          default: state_nxt = S_M1;
        endcase
      end
      S_M1: begin
        cmd.code  = (stat.op == OP_MUL) ? C_M_NN : C_M_T1;
        state_nxt = S_M2;
      end
      S_M2: begin
        case (stat.op)
          OP_ADD:  cmd.code = C_M_T2;
          OP_MUL:  cmd.code = C_M_DD;
          default: cmd.code = C_M_BNAD;
        endcase
        state_nxt = S_M3;
      end
      S_M3: begin
        if (stat.op == OP_ADD) cmd.code = C_M_DD;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.code  = (stat.op == OP_ADD) ? C_ADD_FIX : C_MUL_FIX;
        ph_nxt    = PH_R;
        state_nxt = S_RED_INIT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[hdl/rational_fraction_alu.sv]
// top level of the rational fraction alu: controller plus datapath
// depends on rfa_pkg, rfa_if, rfa_ctrl, rfa_datapath and the assertion header
`timescale 1ns / 1ps
`default_nettype none
`include "rational_fraction_alu_defines.svh"
// rational number alu with gcd reduction. one item at a time: an item is
// taken, its operands are reduced, the opcode runs and the result item is
// held until taken. a zero denominator ends an item early with an error
// result, and an unused opcode ends it early with a zero result and no
// error. a division by a zero b numerator gives an error result after the
// reductions. the time an item takes is set by the binary gcd loop (one
// shift or subtract a cycle) and the restoring divider (one quotient bit a
// cycle, 64 per division, two per reduction), both shared by the reductions
// of a, b and the result. WIDTH picks how many low bits of each operand
// field are used, sign-extended.
module rational_fraction_alu #(
  parameter int WIDTH = rfa_pkg::WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  rfa_in_if.sink   in_ch,
  rfa_out_if.source out_ch
);
  import rfa_pkg::*;

  rfa_cmd_t  cmd;
  rfa_stat_t stat;

  // controller: handshakes and sequencing
  rfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: operand magnitudes, gcd, divider, multiplier, result registers
  rfa_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .opcode   (in_ch.opcode),
    .a_num    (in_ch.a_num),
    .a_den    (in_ch.a_den),
    .b_num    (in_ch.b_num),
    .b_den    (in_ch.b_den),
    .stat     (stat),
    .res_num  (out_ch.res_num),
    .res_den  (out_ch.res_den),
    .is_equal (out_ch.is_equal),
    .status   (out_ch.status)
  );

  // one item in flight: never taking an item while a result waits
  `RFA_ASSERT_IMPL(a_one_item, out_ch.valid, !in_ch.ready, "took item while result pending")
  // an accepted item blocks the input the next cycle
  `RFA_ASSERT_NEXT(a_busy, in_ch.valid && in_ch.ready, !in_ch.ready, "input open after item")
  // error results carry a zero fraction
  `RFA_ASSERT_IMPL(a_err_zero, out_ch.valid && out_ch.status,
                   out_ch.res_num == 64'sd0 && out_ch.res_den == 63'd0, "error result not zero")
  // equality and error never both set
  `RFA_ASSERT_IMPL(a_eq_ok, out_ch.valid && out_ch.is_equal, !out_ch.status,
                   "equal flag with error status")
endmodule
`default_nettype wire
